// ----- rtl/bfa_pkg.sv -----
// shared types and constants of the bitmap first-free allocator
`default_nettype none

package bfa_pkg;

    localparam int BITMAP_BYTES_DEF = 4096;
    localparam int WORD_BYTES       = 8;
    localparam int WORD_BITS        = 64;
    localparam int CFG_AW           = 4;
    localparam int CFG_DW           = 32;
    localparam int SCAN_W           = 13;

    localparam logic [SCAN_W-1:0] SCAN_BYTES_RST = SCAN_W'(1024);

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_SCAN_BYTES  = 2'd0,
        REG_BASE_OFFSET = 2'd1,
        REG_ADD_ONE     = 2'd2
    } t_reg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_RD_RD,
        S_RD_CAP,
        S_SCAN,
        S_AL_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr;
        logic accept;
        logic scan;
        logic ld_wr;
        logic rd_cap;
        logic al_wr;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic scan_hit;
        logic scan_end;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- rtl/bfa_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/bfa_cfg.sv -----
// apb configuration registers of the allocator
`default_nettype none

module bfa_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bfa_pkg::CFG_AW-1:0]    paddr,
    input  wire logic [bfa_pkg::CFG_DW-1:0]    pwdata,
    output logic      [bfa_pkg::CFG_DW-1:0]    prdata,
    output logic      [bfa_pkg::SCAN_W-1:0]    o_scan_bytes,
    output logic      [31:0]                   o_base_offset,
    output logic                               o_add_one
);

    logic [bfa_pkg::SCAN_W-1:0] r_scan_bytes;
    logic [31:0]                r_base_offset;
    logic                       r_add_one;
    logic                       wr_en;
    logic [1:0]                 reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_bytes  <= bfa_pkg::SCAN_BYTES_RST;
            r_base_offset <= '0;
            r_add_one     <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                bfa_pkg::REG_SCAN_BYTES:  r_scan_bytes  <= pwdata[bfa_pkg::SCAN_W-1:0];
                bfa_pkg::REG_BASE_OFFSET: r_base_offset <= pwdata;
                bfa_pkg::REG_ADD_ONE:     r_add_one     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bfa_pkg::REG_SCAN_BYTES:  prdata = bfa_pkg::CFG_DW'(r_scan_bytes);
            bfa_pkg::REG_BASE_OFFSET: prdata = r_base_offset;
            bfa_pkg::REG_ADD_ONE:     prdata = bfa_pkg::CFG_DW'(r_add_one);
            default:                  prdata = '0;
        endcase
    end

    assign o_scan_bytes  = r_scan_bytes;
    assign o_base_offset = r_base_offset;
    assign o_add_one     = r_add_one;

endmodule

`default_nettype wire

// ----- rtl/bfa_ctrl.sv -----
// control state machine of the allocator
`default_nettype none

module bfa_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [1:0]       i_command,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    input  wire bfa_pkg::t_dp_sts i_sts,
    output bfa_pkg::t_dp_cmd      o_cmd
);

    bfa_pkg::t_state r_state;
    bfa_pkg::t_state n_state;
    logic            r_out_valid;
    logic            accept;
    logic            out_free;

    assign accept   = (r_state == bfa_pkg::S_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            bfa_pkg::S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = bfa_pkg::S_IDLE;
                end
            end
            bfa_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        bfa_pkg::CMD_LOAD:  n_state = bfa_pkg::S_LD_RD;
                        bfa_pkg::CMD_ALLOC: n_state = bfa_pkg::S_SCAN;
                        bfa_pkg::CMD_READ:  n_state = bfa_pkg::S_RD_RD;
                        default:            n_state = bfa_pkg::S_DONE;
                    endcase
                end
            end
            bfa_pkg::S_LD_RD:  n_state = bfa_pkg::S_LD_WR;
            bfa_pkg::S_LD_WR:  n_state = bfa_pkg::S_DONE;
            bfa_pkg::S_RD_RD:  n_state = bfa_pkg::S_RD_CAP;
            bfa_pkg::S_RD_CAP: n_state = bfa_pkg::S_DONE;
            bfa_pkg::S_SCAN: begin
                if (i_sts.scan_hit) begin
                    n_state = bfa_pkg::S_AL_WR;
                end else if (i_sts.scan_end) begin
                    n_state = bfa_pkg::S_DONE;
                end
            end
            bfa_pkg::S_AL_WR:  n_state = bfa_pkg::S_DONE;
            bfa_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = bfa_pkg::S_IDLE;
                end
            end
            default:           n_state = bfa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.clr      = (r_state == bfa_pkg::S_CLEAR);
        o_cmd.accept   = accept;
        o_cmd.scan     = (r_state == bfa_pkg::S_SCAN);
        o_cmd.ld_wr    = (r_state == bfa_pkg::S_LD_WR);
        o_cmd.rd_cap   = (r_state == bfa_pkg::S_RD_CAP);
        o_cmd.al_wr    = (r_state == bfa_pkg::S_AL_WR);
        o_cmd.out_load = (r_state == bfa_pkg::S_DONE) && out_free;
        o_in_stall     = (r_state != bfa_pkg::S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfa_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- rtl/bfa_dp.sv -----
// datapath of the allocator: bitmap ram, scan pointers, first-free search, result registers
`default_nettype none

module bfa_dp #(
    parameter int BITMAP_BYTES = bfa_pkg::BITMAP_BYTES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bfa_pkg::t_dp_cmd           i_cmd,
    output bfa_pkg::t_dp_sts                o_sts,
    input  wire logic [11:0]                i_byte_index,
    input  wire logic [7:0]                 i_byte_value,
    input  wire logic [bfa_pkg::SCAN_W-1:0] i_scan_bytes,
    input  wire logic [31:0]                i_base_offset,
    input  wire logic                       i_add_one,
    output logic                            o_found,
    output logic      [31:0]                o_address,
    output logic      [7:0]                 o_read_byte
);

    localparam int WORDS = BITMAP_BYTES / bfa_pkg::WORD_BYTES;
    localparam int WAW   = $clog2(WORDS);
    localparam int LW    = $clog2(BITMAP_BYTES + 1);
    localparam int CW    = (LW > bfa_pkg::SCAN_W) ? LW : bfa_pkg::SCAN_W;
    localparam int WB    = bfa_pkg::WORD_BITS;

    logic [11:0]    r_idx;
    logic [7:0]     r_val;
    logic [WAW-1:0] r_clr_ptr;
    logic [WAW:0]   r_rd_ptr;
    logic [WAW-1:0] r_chk_idx;
    logic           r_chk_valid;
    logic [WAW-1:0] r_hit_idx;
    logic [5:0]     r_hit_pos;
    logic [WB-1:0]  r_hit_word;
    logic           r_res_found;
    logic [31:0]    r_res_addr;
    logic [7:0]     r_res_rbyte;
    logic           r_o_found;
    logic [31:0]    r_o_address;
    logic [7:0]     r_o_read_byte;

    logic [CW-1:0]  lim;
    logic [CW:0]    lim_up;
    logic [WAW:0]   nwords;
    logic [WAW:0]   lim_word;
    logic [2:0]     lim_rem;
    logic           issue;
    logic           idx_ok;
    logic [WAW-1:0] idx_word;
    logic [WB-1:0]  vmask;
    logic [WB-1:0]  free_bits;
    logic           any_free;
    logic [5:0]     free_pos;
    logic [WB-1:0]  merged;
    logic [7:0]     rd_sel;

    logic           ram_we;
    logic [WAW-1:0] ram_waddr;
    logic [WB-1:0]  ram_wdata;
    logic [WAW-1:0] ram_raddr;
    logic [WB-1:0]  ram_rdata;

    bfa_ram #(
        .WIDTH (WB),
        .DEPTH (WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign lim      = (CW'(i_scan_bytes) > CW'(BITMAP_BYTES)) ? CW'(BITMAP_BYTES)
                                                              : CW'(i_scan_bytes);
    assign lim_up   = {1'b0, lim} + (CW + 1)'(7);
    assign nwords   = (WAW + 1)'(lim_up >> 3);
    assign lim_word = (WAW + 1)'(lim >> 3);
    assign lim_rem  = lim[2:0];
    assign issue    = r_rd_ptr < nwords;
    assign idx_ok   = (CW'(r_idx) < CW'(BITMAP_BYTES));
    assign idx_word = WAW'(r_idx >> 3);

    // bytes past the scan limit count as used
    always_comb begin
        vmask = '1;
        if (!({1'b0, r_chk_idx} < lim_word)) begin
            for (int b = 0; b < bfa_pkg::WORD_BYTES; b++) begin
                vmask[8*b +: 8] = (3'(b) < lim_rem) ? 8'hFF : 8'h00;
            end
        end
    end

    assign free_bits = ~ram_rdata & vmask;
    assign any_free  = |free_bits;

    always_comb begin
        free_pos = '0;
        for (int i = WB - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                free_pos = 6'(i);
            end
        end
    end

    always_comb begin
        merged = ram_rdata;
        for (int b = 0; b < bfa_pkg::WORD_BYTES; b++) begin
            if (3'(b) == r_idx[2:0]) begin
                merged[8*b +: 8] = r_val;
            end
        end
    end

    assign rd_sel = 8'(ram_rdata >> {r_idx[2:0], 3'b000});

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_hit_idx;
        ram_wdata = r_hit_word;
        if (i_cmd.clr) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_ptr;
            ram_wdata = '0;
        end else if (i_cmd.ld_wr) begin
            ram_we    = idx_ok;
            ram_waddr = idx_word;
            ram_wdata = merged;
        end else if (i_cmd.al_wr) begin
            ram_we    = 1'b1;
        end
    end

    assign ram_raddr = i_cmd.scan ? r_rd_ptr[WAW-1:0] : idx_word;

    assign o_sts.clr_last = (r_clr_ptr == WAW'(WORDS - 1));
    assign o_sts.scan_hit = r_chk_valid && any_free;
    assign o_sts.scan_end = !r_chk_valid && !issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_ptr   <= '0;
            r_rd_ptr    <= '0;
            r_chk_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_ptr <= r_clr_ptr + WAW'(1);
            end
            if (i_cmd.accept) begin
                r_rd_ptr    <= '0;
                r_chk_valid <= 1'b0;
            end else if (i_cmd.scan) begin
                r_chk_valid <= issue;
                if (issue) begin
                    r_rd_ptr <= r_rd_ptr + (WAW + 1)'(1);
                end
            end else begin
                r_chk_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx       <= i_byte_index;
            r_val       <= i_byte_value;
            r_res_found <= 1'b0;
            r_res_addr  <= '0;
            r_res_rbyte <= '0;
        end
        if (i_cmd.scan) begin
            r_chk_idx <= r_rd_ptr[WAW-1:0];
            if (o_sts.scan_hit) begin
                r_hit_idx  <= r_chk_idx;
                r_hit_pos  <= free_pos;
                r_hit_word <= ram_rdata | (WB'(1) << free_pos);
            end
        end
        if (i_cmd.rd_cap) begin
            r_res_rbyte <= idx_ok ? rd_sel : 8'h00;
        end
        if (i_cmd.al_wr) begin
            r_res_found <= 1'b1;
            r_res_addr  <= i_base_offset + 32'({r_hit_idx, r_hit_pos}) + 32'(i_add_one);
        end
        if (i_cmd.out_load) begin
            r_o_found     <= r_res_found;
            r_o_address   <= r_res_addr;
            r_o_read_byte <= r_res_rbyte;
        end
    end

    assign o_found     = r_o_found;
    assign o_address   = r_o_address;
    assign o_read_byte = r_o_read_byte;

endmodule

`default_nettype wire

// ----- rtl/bitmap_first_free_allocator_core.sv -----
// top level of the bitmap first-free allocator
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  in       | i_in_valid / o_in_stall    | i_command, i_byte_index, i_byte_value
//  out      | o_out_valid / i_out_stall  | o_found, o_address, o_read_byte
//  config   | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
//  after reset a clearing pass writes BITMAP_BYTES/8 zero words, one a cycle, input stalled
//  load reads a bitmap word and writes it back with the byte merged in, read captures one byte
//  allocate scans up to ceil(limit/8) words: the bitmap ram gives one 64-bit word a cycle
//  one transfer is worked on at a time; the next is taken while the last result still waits
//  reset is synchronous and active low
`default_nettype none

module bitmap_first_free_allocator_core #(
    parameter int BITMAP_BYTES = bfa_pkg::BITMAP_BYTES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [1:0]                 i_command,
    input  wire logic [11:0]                i_byte_index,
    input  wire logic [7:0]                 i_byte_value,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic                            o_found,
    output logic      [31:0]                o_address,
    output logic      [7:0]                 o_read_byte,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bfa_pkg::CFG_AW-1:0] paddr,
    input  wire logic [bfa_pkg::CFG_DW-1:0] pwdata,
    output logic      [bfa_pkg::CFG_DW-1:0] prdata,
    output logic                            pready
);

    bfa_pkg::t_dp_cmd           dp_cmd;
    bfa_pkg::t_dp_sts           dp_sts;
    logic [bfa_pkg::SCAN_W-1:0] scan_bytes;
    logic [31:0]                base_offset;
    logic                       add_one;

    assign pready = 1'b1;

    bfa_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .o_scan_bytes  (scan_bytes),
        .o_base_offset (base_offset),
        .o_add_one     (add_one)
    );

    bfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    bfa_dp #(
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_byte_index  (i_byte_index),
        .i_byte_value  (i_byte_value),
        .i_scan_bytes  (scan_bytes),
        .i_base_offset (base_offset),
        .i_add_one     (add_one),
        .o_found       (o_found),
        .o_address     (o_address),
        .o_read_byte   (o_read_byte)
    );

endmodule

`default_nettype wire
